### hdl/pwud_pkg.sv
// Shared constants for the priority work-unit dispatcher.
package pwud_pkg;

    // Default sizes
    localparam int MAX_JOBS_DEF  = 8;
    localparam int UNIT_BITS_DEF = 16;

    // Field widths fixed by the stream format
    localparam int MODE_W   = 2;
    localparam int JOB_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_SUBMIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOLICIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_UNIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd3;

endpackage

### hdl/priority_work_unit_dispatcher_core.sv
// Priority work-unit dispatcher: job table, sequencer and single shared scan unit.
// Submit does a scan pass, a shift pass and a write (scan only on a full table); solicit
// a scan pass and a write (no write with nothing to hand out); complete a read, an update
// and, if it frees the job, a shift pass. Zero count, bad slot or unknown mode go straight
// to the result. One request at a time: ready returns the cycle after the result is loaded.
// Reset clears the valid bits, job count and output valid; table contents are not cleared.
module priority_work_unit_dispatcher_core #(
    parameter int MAX_JOBS  = pwud_pkg::MAX_JOBS_DEF,
    parameter int UNIT_BITS = pwud_pkg::UNIT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // mode[1:0], job_id[17:2], unit_count[33:18], priority_req[41:34], slot[44:42]
    input  logic [pwud_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // status[1:0], out_slot[4:2], out_job_id[20:5], grant_index[36:21], job_done[37]
    output logic [pwud_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);
    import pwud_pkg::*;

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB_SCAN,
        S_SUB_SHIFT,
        S_SUB_WRITE,
        S_SOL_SCAN,
        S_SOL_WRITE,
        S_CPL_READ,
        S_CPL_UPD,
        S_CPL_SHIFT,
        S_RESP
    } state_t;

    // Job table storage
    logic signed [PRIO_W-1:0]  prio_mem  [MAX_JOBS];
    logic [JOB_W-1:0]          job_mem   [MAX_JOBS];
    logic [UNIT_BITS-1:0]      total_mem [MAX_JOBS];
    logic [UNIT_BITS-1:0]      next_mem  [MAX_JOBS];
    logic [UNIT_BITS-1:0]      fin_mem   [MAX_JOBS];
    logic [IDX_W-1:0]          rank_mem  [MAX_JOBS];

    logic signed [PRIO_W-1:0]  prio_rd_reg;
    logic [JOB_W-1:0]          job_rd_reg;
    logic [UNIT_BITS-1:0]      total_rd_reg;
    logic [UNIT_BITS-1:0]      next_rd_reg;
    logic [UNIT_BITS-1:0]      fin_rd_reg;
    logic [IDX_W-1:0]          rank_rd_reg;

    // Control and request registers
    state_t                    state_reg;
    logic [MAX_JOBS-1:0]       valid_reg;
    logic [CNT_W-1:0]          used_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic                      proc_vld_reg;
    logic [IDX_W-1:0]          proc_idx_reg;
    logic [CNT_W-1:0]          pos_reg;
    logic                      found_reg;
    logic [IDX_W-1:0]          hit_slot_reg;
    logic [IDX_W-1:0]          hit_rank_reg;
    logic [JOB_W-1:0]          hit_job_reg;
    logic [UNIT_BITS-1:0]      hit_next_reg;

    logic [JOB_W-1:0]          req_job_reg;
    logic [COUNT_W-1:0]        req_count_reg;
    logic signed [PRIO_W-1:0]  req_prio_reg;
    logic [IDX_W-1:0]          req_slot_reg;

    logic [STATUS_W-1:0]       res_status_reg;
    logic [SLOT_W-1:0]         res_slot_reg;
    logic [JOB_W-1:0]          res_job_reg;
    logic [INDEX_W-1:0]        res_unit_reg;
    logic                      res_done_reg;

    logic [OUT_TDATA_W-1:0]    m_tdata_reg;
    logic                      m_tvalid_reg;

    // Input field unpacking
    logic [MODE_W-1:0]         in_mode;
    logic [JOB_W-1:0]          in_job;
    logic [COUNT_W-1:0]        in_count;
    logic signed [PRIO_W-1:0]  in_prio;
    logic [SLOT_W-1:0]         in_slot;
    logic [IDX_W-1:0]          in_slot_idx;
    logic                      in_slot_ok;
    logic                      in_count_bad;

    assign in_mode     = s_tdata[1:0];
    assign in_job      = s_tdata[17:2];
    assign in_count    = s_tdata[33:18];
    assign in_prio     = s_tdata[41:34];
    assign in_slot     = s_tdata[44:42];
    assign in_slot_idx = IDX_W'(in_slot);
    assign in_slot_ok  = (32'(in_slot) < MAX_JOBS) && valid_reg[in_slot_idx];
    assign in_count_bad = (in_count == '0) || ((32'(in_count) >> UNIT_BITS) != 0);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // Scan unit: entry under test and end of pass
    logic                      scan_end;
    logic                      proc_valid;
    logic [CNT_W-1:0]          rank_rd_ext;
    logic [UNIT_BITS-1:0]      fin_inc;

    assign scan_end    = (idx_reg == CNT_W'(MAX_JOBS));
    assign proc_valid  = proc_vld_reg && valid_reg[proc_idx_reg];
    assign rank_rd_ext = CNT_W'(rank_rd_reg);
    assign fin_inc     = fin_rd_reg + 1'b1;

    // Hits on the entry under test; the last entry is tested in the end-of-pass cycle
    logic                      sub_free_hit;
    logic                      sol_hit;

    assign sub_free_hit = proc_vld_reg && !valid_reg[proc_idx_reg] && !found_reg;
    assign sol_hit      = proc_valid && (next_rd_reg < total_rd_reg) &&
                          (!found_reg || (rank_rd_reg < hit_rank_reg));

    // Table port control
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic                      wr_entry_en;
    logic                      wr_rank_en;
    logic                      wr_next_en;
    logic                      wr_fin_en;
    logic [IDX_W-1:0]          wr_rank_data;
    logic [UNIT_BITS-1:0]      wr_next_data;
    logic [UNIT_BITS-1:0]      wr_fin_data;

    always_comb
    begin
        rd_addr      = '0;
        wr_addr      = hit_slot_reg;
        wr_entry_en  = 1'b0;
        wr_rank_en   = 1'b0;
        wr_next_en   = 1'b0;
        wr_fin_en    = 1'b0;
        wr_rank_data = rank_rd_reg;
        wr_next_data = '0;
        wr_fin_data  = '0;
        if (!scan_end)
        begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
        case (state_reg)
            S_SUB_SHIFT:
            begin
                wr_addr      = proc_idx_reg;
                wr_rank_en   = proc_valid && (rank_rd_ext >= pos_reg);
                wr_rank_data = rank_rd_reg + 1'b1;
            end
            S_SUB_WRITE:
            begin
                wr_entry_en  = 1'b1;
                wr_rank_en   = 1'b1;
                wr_next_en   = 1'b1;
                wr_fin_en    = 1'b1;
                wr_rank_data = IDX_W'(pos_reg);
            end
            S_SOL_WRITE:
            begin
                wr_next_en   = 1'b1;
                wr_next_data = hit_next_reg + 1'b1;
            end
            S_CPL_READ:
            begin
                rd_addr = req_slot_reg;
            end
            S_CPL_UPD:
            begin
                wr_addr     = req_slot_reg;
                wr_fin_en   = 1'b1;
                wr_fin_data = fin_inc;
            end
            S_CPL_SHIFT:
            begin
                wr_addr      = proc_idx_reg;
                wr_rank_en   = proc_valid && (rank_rd_ext > pos_reg);
                wr_rank_data = rank_rd_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Table memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_entry_en)
        begin
            prio_mem[wr_addr]  <= req_prio_reg;
            job_mem[wr_addr]   <= req_job_reg;
            total_mem[wr_addr] <= UNIT_BITS'(req_count_reg);
        end
        if (wr_rank_en)
        begin
            rank_mem[wr_addr] <= wr_rank_data;
        end
        if (wr_next_en)
        begin
            next_mem[wr_addr] <= wr_next_data;
        end
        if (wr_fin_en)
        begin
            fin_mem[wr_addr] <= wr_fin_data;
        end
        prio_rd_reg  <= prio_mem[rd_addr];
        job_rd_reg   <= job_mem[rd_addr];
        total_rd_reg <= total_mem[rd_addr];
        next_rd_reg  <= next_mem[rd_addr];
        fin_rd_reg   <= fin_mem[rd_addr];
        rank_rd_reg  <= rank_mem[rd_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            used_reg       <= '0;
            idx_reg        <= '0;
            proc_vld_reg   <= 1'b0;
            proc_idx_reg   <= '0;
            pos_reg        <= '0;
            found_reg      <= 1'b0;
            hit_slot_reg   <= '0;
            hit_rank_reg   <= '0;
            hit_job_reg    <= '0;
            hit_next_reg   <= '0;
            req_job_reg    <= '0;
            req_count_reg  <= '0;
            req_prio_reg   <= '0;
            req_slot_reg   <= '0;
            res_status_reg <= ST_OK;
            res_slot_reg   <= '0;
            res_job_reg    <= '0;
            res_unit_reg   <= '0;
            res_done_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            // scan pointer runs in every pass state
            idx_reg      <= idx_reg + 1'b1;
            proc_vld_reg <= !scan_end;
            proc_idx_reg <= idx_reg[IDX_W-1:0];

            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    idx_reg        <= '0;
                    proc_vld_reg   <= 1'b0;
                    found_reg      <= 1'b0;
                    pos_reg        <= used_reg;
                    req_job_reg    <= in_job;
                    req_count_reg  <= in_count;
                    req_prio_reg   <= in_prio;
                    req_slot_reg   <= in_slot_idx;
                    res_status_reg <= ST_BAD;
                    res_slot_reg   <= '0;
                    res_job_reg    <= '0;
                    res_unit_reg   <= '0;
                    res_done_reg   <= 1'b0;
                    if (s_tvalid)
                    begin
                        case (in_mode)
                            MODE_SUBMIT:
                            begin
                                state_reg <= in_count_bad ? S_RESP : S_SUB_SCAN;
                            end
                            MODE_SOLICIT:
                            begin
                                state_reg <= S_SOL_SCAN;
                            end
                            MODE_COMPLETE:
                            begin
                                res_slot_reg <= in_slot;
                                state_reg    <= in_slot_ok ? S_CPL_READ : S_RESP;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end

                // lowest free slot and insertion rank
                S_SUB_SCAN:
                begin
                    if (sub_free_hit)
                    begin
                        found_reg    <= 1'b1;
                        hit_slot_reg <= proc_idx_reg;
                    end
                    if (proc_valid && (prio_rd_reg < req_prio_reg) && (rank_rd_ext < pos_reg))
                    begin
                        pos_reg <= rank_rd_ext;
                    end
                    if (scan_end)
                    begin
                        idx_reg      <= '0;
                        proc_vld_reg <= 1'b0;
                        if (found_reg || sub_free_hit)
                        begin
                            state_reg <= S_SUB_SHIFT;
                        end
                        else
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_RESP;
                        end
                    end
                end

                // open a gap in the service order
                S_SUB_SHIFT:
                begin
                    if (scan_end)
                    begin
                        state_reg <= S_SUB_WRITE;
                    end
                end

                S_SUB_WRITE:
                begin
                    valid_reg[hit_slot_reg] <= 1'b1;
                    used_reg       <= used_reg + 1'b1;
                    res_status_reg <= ST_OK;
                    res_slot_reg   <= SLOT_W'(hit_slot_reg);
                    res_job_reg    <= req_job_reg;
                    state_reg      <= S_RESP;
                end

                // first job in order with units left
                S_SOL_SCAN:
                begin
                    if (sol_hit)
                    begin
                        found_reg    <= 1'b1;
                        hit_slot_reg <= proc_idx_reg;
                        hit_rank_reg <= rank_rd_reg;
                        hit_job_reg  <= job_rd_reg;
                        hit_next_reg <= next_rd_reg;
                    end
                    if (scan_end)
                    begin
                        if (found_reg || sol_hit)
                        begin
                            state_reg <= S_SOL_WRITE;
                        end
                        else
                        begin
                            res_status_reg <= ST_NO_UNIT;
                            state_reg      <= S_RESP;
                        end
                    end
                end

                S_SOL_WRITE:
                begin
                    res_status_reg <= ST_OK;
                    res_slot_reg   <= SLOT_W'(hit_slot_reg);
                    res_job_reg    <= hit_job_reg;
                    res_unit_reg   <= INDEX_W'(hit_next_reg);
                    state_reg      <= S_RESP;
                end

                S_CPL_READ:
                begin
                    state_reg <= S_CPL_UPD;
                end

                // count the unit, free the slot on the last one
                S_CPL_UPD:
                begin
                    res_status_reg <= ST_OK;
                    res_job_reg    <= job_rd_reg;
                    if (fin_inc >= total_rd_reg)
                    begin
                        valid_reg[req_slot_reg] <= 1'b0;
                        used_reg     <= used_reg - 1'b1;
                        pos_reg      <= rank_rd_ext;
                        res_done_reg <= 1'b1;
                        idx_reg      <= '0;
                        proc_vld_reg <= 1'b0;
                        state_reg    <= S_CPL_SHIFT;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end

                // close the gap in the service order
                S_CPL_SHIFT:
                begin
                    if (scan_end)
                    begin
                        state_reg <= S_RESP;
                    end
                end

                // hand the result to the output register once it is free
                S_RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {2'b00, res_done_reg, res_unit_reg, res_job_reg,
                                         res_slot_reg, res_status_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### verif/priority_work_unit_dispatcher_core_tb.sv
// Self-checking testbench for the priority work-unit dispatcher core.
`timescale 1ns / 1ps

module priority_work_unit_dispatcher_core_tb;
    import pwud_pkg::*;

    localparam int          MAX_JOBS    = MAX_JOBS_DEF;
    localparam int          RAND_ITEMS  = 1350;
    localparam int          TAIL_CYCLES = 40;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          IDLE_PCT    = 38;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;    // spare request code, must be rejected

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [JOB_W-1:0]          job_id;
        logic [COUNT_W-1:0]        unit_count;
        logic signed [PRIO_W-1:0]  prio;
        logic [SLOT_W-1:0]         slot;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOT_W-1:0]    slot;
        logic [JOB_W-1:0]     job_id;
        logic [INDEX_W-1:0]   grant_index;
        logic                 job_done;
    } reply_t;

    typedef struct packed {
        request_t  req;
        logic      typed;   // reply below is fixed by hand
        reply_t    reply;
    } script_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;

    logic                    quiet = 1'b0;   // no idling on either side while set
    int                      mismatches = 0;
    int                      cycle_count = 0;

    // Shadow copy of the job table
    logic                       tbl_valid    [MAX_JOBS];
    logic signed [PRIO_W-1:0]   tbl_prio     [MAX_JOBS];
    logic [JOB_W-1:0]           tbl_job      [MAX_JOBS];
    logic [COUNT_W-1:0]         tbl_total    [MAX_JOBS];
    logic [INDEX_W-1:0]         tbl_next     [MAX_JOBS];
    logic [COUNT_W-1:0]         tbl_finished [MAX_JOBS];
    logic [SLOT_W-1:0]          tbl_rank     [MAX_JOBS];
    int                         jobs_held = 0;

    reply_t       replies_due [$];
    script_row_t  script_rows [$];

    priority_work_unit_dispatcher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #1 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

    // mode[1:0], job_id[17:2], unit_count[33:18], priority_req[41:34], slot[44:42]
    function automatic logic [IN_TDATA_W-1:0] pack_request(request_t r);
        logic [IN_TDATA_W-1:0] d;
        d        = '0;
        d[1:0]   = r.mode;
        d[17:2]  = r.job_id;
        d[33:18] = r.unit_count;
        d[41:34] = r.prio;
        d[44:42] = r.slot;
        return d;
    endfunction

    // Next reply of the dispatcher; updates the shadow table
    function automatic reply_t dispatch_predict(request_t r);
        reply_t       rp;
        int           free_slot;
        int           pos;
        int           best;
        int           best_rank;
        int           i;
        logic [2:0]   freed_rank;
        rp        = '0;
        free_slot = MAX_JOBS;
        best      = MAX_JOBS;
        best_rank = MAX_JOBS + 1;
        case (r.mode)
            MODE_SUBMIT:
            begin
                for (i = MAX_JOBS - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        free_slot = i;
                if (r.unit_count == '0)
                    rp.status = ST_BAD;
                else if (free_slot >= MAX_JOBS)
                    rp.status = ST_FULL;
                else
                begin
                    // goes in front of the first job of strictly lower priority
                    pos = jobs_held;
                    for (i = 0; i < MAX_JOBS; i++)
                        if (tbl_valid[i] && $signed(tbl_prio[i]) < $signed(r.prio)
                            && int'(tbl_rank[i]) < pos)
                            pos = int'(tbl_rank[i]);
                    for (i = 0; i < MAX_JOBS; i++)
                        if (tbl_valid[i] && int'(tbl_rank[i]) >= pos)
                            tbl_rank[i] = tbl_rank[i] + 1'b1;
                    tbl_valid[free_slot]    = 1'b1;
                    tbl_prio[free_slot]     = r.prio;
                    tbl_job[free_slot]      = r.job_id;
                    tbl_total[free_slot]    = r.unit_count;
                    tbl_next[free_slot]     = '0;
                    tbl_finished[free_slot] = '0;
                    tbl_rank[free_slot]     = pos[SLOT_W-1:0];
                    jobs_held++;
                    rp.status = ST_OK;
                    rp.slot   = free_slot[SLOT_W-1:0];
                    rp.job_id = r.job_id;
                end
            end
            MODE_SOLICIT:
            begin
                for (i = 0; i < MAX_JOBS; i++)
                    if (tbl_valid[i] && tbl_next[i] < tbl_total[i]
                        && int'(tbl_rank[i]) < best_rank)
                    begin
                        best      = i;
                        best_rank = int'(tbl_rank[i]);
                    end
                if (best >= MAX_JOBS)
                    rp.status = ST_NO_UNIT;
                else
                begin
                    rp.status      = ST_OK;
                    rp.slot        = best[SLOT_W-1:0];
                    rp.job_id      = tbl_job[best];
                    rp.grant_index = tbl_next[best];
                    tbl_next[best] = tbl_next[best] + 1'b1;
                end
            end
            MODE_COMPLETE:
            begin
                rp.slot = r.slot;
                if (!tbl_valid[r.slot])
                    rp.status = ST_BAD;
                else
                begin
                    // counted even if the unit was never handed out
                    rp.status = ST_OK;
                    rp.job_id = tbl_job[r.slot];
                    tbl_finished[r.slot] = tbl_finished[r.slot] + 1'b1;
                    if (tbl_finished[r.slot] >= tbl_total[r.slot])
                    begin
                        freed_rank = tbl_rank[r.slot];
                        tbl_valid[r.slot] = 1'b0;
                        for (i = 0; i < MAX_JOBS; i++)
                            if (tbl_valid[i] && tbl_rank[i] > freed_rank)
                                tbl_rank[i] = tbl_rank[i] - 1'b1;
                        jobs_held--;
                        rp.job_done = 1'b1;
                    end
                end
            end
            default:
                rp.status = ST_BAD;
        endcase
        return rp;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result transaction with no request outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                compare_field("status",      32'(want.status),      32'(m_tdata[1:0]));
                compare_field("out_slot",    32'(want.slot),        32'(m_tdata[4:2]));
                compare_field("out_job_id",  32'(want.job_id),      32'(m_tdata[20:5]));
                compare_field("grant_index", 32'(want.grant_index), 32'(m_tdata[36:21]));
                compare_field("job_done",    32'(want.job_done),    32'(m_tdata[37]));
            end
        end
    end

    // One request transaction; returns at the edge that accepts it
    task automatic send_request(input request_t r, input reply_t want);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        replies_due.push_back(want);
        s_tdata  <= pack_request(r);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (replies_due.size() != 0);
    endtask

    task automatic add_row(input logic [1:0] mode, input logic [15:0] job,
                           input logic [15:0] cnt, input logic [7:0] prio,
                           input logic [2:0] slot, input logic typed,
                           input logic [1:0] st, input logic [2:0] oslot,
                           input logic [15:0] ojob, input logic done);
        script_row_t row;
        row.req   = '{mode, job, cnt, prio, slot};
        row.typed = typed;
        row.reply = '{st, oslot, ojob, 16'd0, done};
        script_rows.push_back(row);
    endtask

    // Stimulus
    initial
    begin
        request_t     r;
        reply_t       predicted;
        int           n;
        int           k;
        int           pick;
        int           roll;
        int           w_sub;
        int           w_sol;
        logic         found;
        logic [63:0]  rnd;

        for (k = 0; k < MAX_JOBS; k++)
            tbl_valid[k] = 1'b0;

        // Directed rows: empty table, rejects, fill, ordering, early complete
        add_row(MODE_SOLICIT,  16'h0000, 16'h0000, 8'h00, 3'd0, 1'b1, ST_NO_UNIT, 3'd0, 16'h0,
                1'b0);
        add_row(MODE_COMPLETE, 16'h0000, 16'h0000, 8'h00, 3'd5, 1'b1, ST_BAD, 3'd5, 16'h0, 1'b0);
        add_row(MODE_UNUSED,   16'hFFFF, 16'hFFFF, 8'hFF, 3'd7, 1'b1, ST_BAD, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'hFFFF, 16'h0000, 8'h7F, 3'd7, 1'b1, ST_BAD, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'hFFFF, 16'h0002, 8'h7F, 3'd7, 1'b1, ST_OK, 3'd0, 16'hFFFF, 1'b0);
        add_row(MODE_SUBMIT,   16'h0000, 16'h0001, 8'h80, 3'd0, 1'b1, ST_OK, 3'd1, 16'h0000, 1'b0);
        add_row(MODE_SUBMIT,   16'h1234, 16'h0003, 8'h00, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'h00AA, 16'h0002, 8'h00, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'h5555, 16'h0001, 8'h7F, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'h0F0F, 16'h0002, 8'hFF, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'hF0F0, 16'h0004, 8'h05, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'h8001, 16'h0001, 8'h80, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_SUBMIT,   16'hAAAA, 16'hFFFF, 8'h37, 3'd0, 1'b1, ST_FULL, 3'd0, 16'h0, 1'b0);
        // count check comes before the full check
        add_row(MODE_SUBMIT,   16'hAAAA, 16'h0000, 8'h37, 3'd0, 1'b1, ST_BAD, 3'd0, 16'h0, 1'b0);
        for (k = 0; k < 4; k++)
            add_row(MODE_SOLICIT, 16'h0, 16'h0, 8'h00, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_COMPLETE, 16'h0000, 16'h0000, 8'h00, 3'd1, 1'b1, ST_OK, 3'd1, 16'h0000, 1'b1);
        add_row(MODE_COMPLETE, 16'h0000, 16'h0000, 8'h00, 3'd1, 1'b1, ST_BAD, 3'd1, 16'h0, 1'b0);
        add_row(MODE_COMPLETE, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_COMPLETE, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        for (k = 0; k < 3; k++)
            add_row(MODE_SOLICIT, 16'h0, 16'h0, 8'h00, 3'd0, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);
        add_row(MODE_COMPLETE, 16'h0000, 16'h0000, 8'h00, 3'd7, 1'b0, ST_OK, 3'd0, 16'h0, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i])
        begin
            predicted = dispatch_predict(script_rows[i].req);
            send_request(script_rows[i].req,
                         script_rows[i].typed ? script_rows[i].reply : predicted);
        end

        // Random traffic, mostly well-formed against the current table
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            quiet <= (n >= 500 && n < 700);
            if (n == 900)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            rnd    = {$urandom, $urandom};
            r      = request_t'(rnd[$bits(request_t)-1:0]);
            roll   = $urandom_range(99);
            w_sub  = (jobs_held < 2) ? 45 : (jobs_held == MAX_JOBS) ? 10 : 30;
            w_sol  = (jobs_held == MAX_JOBS) ? 40 : 35;
            if (roll < 3)
                r.mode = MODE_UNUSED;
            else if (roll < 3 + w_sub)
            begin
                r.mode = MODE_SUBMIT;
                if (jobs_held < MAX_JOBS)
                begin
                    roll = $urandom_range(99);
                    if (roll < 4)
                        r.unit_count = '0;
                    else if (roll < 70)
                        r.unit_count = COUNT_W'($urandom_range(4, 1));
                    else
                        r.unit_count = COUNT_W'($urandom_range(24, 5));
                end
                // ties are common when priorities come from a narrow set
                if ($urandom_range(1) == 0)
                begin
                    case ($urandom_range(3))
                        0: r.prio = 8'sh80;
                        1: r.prio = 8'sh7F;
                        default: r.prio = PRIO_W'($urandom_range(2));
                    endcase
                end
            end
            else if (roll < 3 + w_sub + w_sol)
                r.mode = MODE_SOLICIT;
            else
            begin
                r.mode = MODE_COMPLETE;
                if ($urandom_range(99) < 88)
                begin
                    pick  = $urandom_range(MAX_JOBS - 1);
                    found = 1'b0;
                    for (k = 0; k < MAX_JOBS; k++)
                        if (!found && tbl_valid[(pick + k) % MAX_JOBS])
                        begin
                            r.slot = SLOT_W'((pick + k) % MAX_JOBS);
                            found  = 1'b1;
                        end
                end
            end
            predicted = dispatch_predict(r);
            send_request(r, predicted);
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### priority_work_unit_dispatcher_core.f
hdl/pwud_pkg.sv
hdl/priority_work_unit_dispatcher_core.sv
verif/priority_work_unit_dispatcher_core_tb.sv
